[hdl/fading_room_led_frame_buffer_core_macros.svh]
// assertion macros shared by the frame buffer modules
// no dependencies; taken in by `include where assertions are written
`ifndef FADING_ROOM_LED_FRAME_BUFFER_CORE_MACROS_SVH
`define FADING_ROOM_LED_FRAME_BUFFER_CORE_MACROS_SVH

// condition holds in the same cycle
`define FRLFB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the antecedent
`define FRLFB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/frlfb_pkg.sv]
// types, constants and pixel helper functions for the room led frame buffer
// no dependencies
package frlfb_pkg;

   localparam int PIXEL_COUNT = 32;
   localparam int ROOM_SLOTS  = 8;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // pixels below this index belong to a room block
   localparam int FRAME_PIXELS = 32;

   typedef struct packed {
      logic        operation;
      logic [2:0]  floor_number;
      logic [2:0]  room_number;
      logic [23:0] room_color;
   } req_type;

   typedef struct packed {
      logic [4:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // control from the sequencer to the pending room store
   typedef struct packed {
      logic        wr_en;
      logic [2:0]  wr_slot;
      logic [23:0] wr_color;
      logic        clear;
      logic [2:0]  rd_slot;
   } room_ctrl_type;

   function automatic logic [7:0] dim_channel(input logic [7:0] c);
      return (c != 8'd0) ? c - 8'd1 : 8'd0;
   endfunction

   function automatic pixel_type fade_pixel(input pixel_type p);
      pixel_type q;
      q.red   = dim_channel(p.red);
      q.green = dim_channel(p.green);
      q.blue  = dim_channel(p.blue);
      return q;
   endfunction

   // pixel index bits: 4 = room bit 0, 3 = lower row, 2 = floor, 1 = room bit 1, 0 = right column
   function automatic logic [2:0] slot_of_pixel(input logic [4:0] idx);
      return {idx[2], idx[1], idx[4]};
   endfunction

endpackage

[hdl/frlfb_pixel_cell.sv]
// one pixel cell of the rotating pixel ring
// depends on frlfb_pkg
module frlfb_pixel_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  frlfb_pkg::pixel_type shift_data,
   output frlfb_pkg::pixel_type pixel_out
);

   frlfb_pkg::pixel_type pixel_ff;
   frlfb_pkg::pixel_type pixel_in;

   always_comb begin
      pixel_in = shift_en ? shift_data : pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff <= '0;
      end else begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel_out = pixel_ff;

endmodule

[hdl/frlfb_room_store.sv]
// pending room colours, one per floor and room, cleared after each tick
// depends on frlfb_pkg
module frlfb_room_store #(
   parameter int ROOM_SLOTS = frlfb_pkg::ROOM_SLOTS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  frlfb_pkg::room_ctrl_type ctrl,
   output logic [23:0]              rd_color
);

   localparam int SLOT_W = $clog2(ROOM_SLOTS);

   logic [23:0] pending_ff [ROOM_SLOTS];
   logic [23:0] pending_in [ROOM_SLOTS];

   always_comb begin
      for (int s = 0; s < ROOM_SLOTS; s++) begin
         if (ctrl.clear) begin
            pending_in[s] = '0;
         end else if (ctrl.wr_en && ctrl.wr_slot[SLOT_W-1:0] == SLOT_W'(s)) begin
            pending_in[s] = ctrl.wr_color;
         end else begin
            pending_in[s] = pending_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < ROOM_SLOTS; s++) begin
            pending_ff[s] <= '0;
         end
      end else begin
         for (int s = 0; s < ROOM_SLOTS; s++) begin
            pending_ff[s] <= pending_in[s];
         end
      end
   end

   assign rd_color = pending_ff[ctrl.rd_slot[SLOT_W-1:0]];

endmodule

[hdl/fading_room_led_frame_buffer_core.sv]
// Room led frame buffer with fading: eight pending room colours and a ring of
// pixel cells. Depends on frlfb_pkg, frlfb_pixel_cell, frlfb_room_store and
// the assertion macro header.
//
// Input channel req_*: a write transfer (operation 0) stores a room colour for
// floor 1..2, room 1..4; other floors or rooms are dropped.
// A tick transfer (operation 1) fades every pixel by one per channel, paints
// each non-zero pending room onto its 2x2 block and streams all PIXEL_COUNT
// pixels on rsp_* in index order, last_pixel marking the final one; pending
// rooms are then cleared.
// A tick transfer moves the state to run, and the first pixel is then loaded into the output register.
// Throughput: one pixel per cycle while rsp_ready is high; req_ready is low for
// the whole run, so no new transfer is taken until the run is over. The pixel
// ring rotates one cell per emitted pixel and returns to its original order
// after a full run.
// A stalled receiver holds the output register and freezes the ring.
// Reset clears all pixels and pending rooms at once, no clearing pass.
`include "fading_room_led_frame_buffer_core_macros.svh"

module fading_room_led_frame_buffer_core #(
   parameter int PIXEL_COUNT = frlfb_pkg::PIXEL_COUNT,
   parameter int ROOM_SLOTS  = frlfb_pkg::ROOM_SLOTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  frlfb_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output frlfb_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(PIXEL_COUNT);

   frlfb_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   frlfb_pkg::rsp_type   rsp_ff, rsp_in;

   frlfb_pkg::pixel_type cell_q [PIXEL_COUNT];
   frlfb_pkg::pixel_type new_pixel;
   frlfb_pkg::pixel_type faded;
   frlfb_pkg::room_ctrl_type room_ctrl;
   logic [23:0]          room_color;

   logic req_xfer, tick_xfer, write_xfer, range_ok;
   logic load, last, in_frame, paint;
   logic [CNT_W:0] cnt_ext;

   // handshake and sequencing
   assign req_xfer   = req_valid && req_ready;
   assign tick_xfer  = req_xfer && (req_data.operation == frlfb_pkg::OP_TICK);
   assign range_ok   = (req_data.floor_number inside {[3'd1:3'd2]}) &&
                       (req_data.room_number inside {[3'd1:3'd4]});
   assign write_xfer = req_xfer && (req_data.operation == frlfb_pkg::OP_WRITE) && range_ok;
   assign load       = (state_ff == frlfb_pkg::ST_RUN) && (!rsp_valid_ff || rsp_ready);
   assign last       = (cnt_ff == CNT_W'(PIXEL_COUNT - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         frlfb_pkg::ST_IDLE: begin
            if (tick_xfer) begin
               state_in = frlfb_pkg::ST_RUN;
            end
         end
         frlfb_pkg::ST_RUN: begin
            if (load && last) begin
               state_in = frlfb_pkg::ST_IDLE;
            end
         end
         default: state_in = frlfb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         frlfb_pkg::ST_IDLE: req_ready = 1'b1;
         frlfb_pkg::ST_RUN:  req_ready = 1'b0;
         default:            req_ready = 1'b0;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (tick_xfer) begin
         cnt_in = '0;
      end else if (load) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // pending room lookup follows the pixel at the head of the ring
   always_comb begin
      room_ctrl.wr_en    = write_xfer;
      room_ctrl.wr_slot  = {req_data.floor_number[1] == 1'b1 ? 1'b1 : 1'b0,
                            2'(req_data.room_number - 3'd1)};
      room_ctrl.wr_color = req_data.room_color;
      room_ctrl.clear    = load && last;
      room_ctrl.rd_slot  = frlfb_pkg::slot_of_pixel(cnt_ff[4:0]);
   end

   frlfb_room_store #(
      .ROOM_SLOTS (ROOM_SLOTS)
   ) u_room_store (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (room_ctrl),
      .rd_color (room_color)
   );

   // head pixel: fade, then paint when its room has a colour pending
   assign cnt_ext   = {1'b0, cnt_ff};
   assign in_frame  = (cnt_ext < (CNT_W+1)'(frlfb_pkg::FRAME_PIXELS));
   assign paint     = in_frame && (room_color != 24'd0);
   assign faded     = frlfb_pkg::fade_pixel(cell_q[0]);
   assign new_pixel = paint ? frlfb_pkg::pixel_type'(room_color) : faded;

   for (genvar k = 0; k < PIXEL_COUNT; k++) begin : g_cell
      frlfb_pkg::pixel_type shift_src;
      if (k == PIXEL_COUNT - 1) begin : g_tail
         assign shift_src = new_pixel;
      end else begin : g_body
         assign shift_src = cell_q[k+1];
      end
      frlfb_pixel_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (load),
         .shift_data (shift_src),
         .pixel_out  (cell_q[k])
      );
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.pixel_index = cnt_ff[4:0];
         rsp_in.red         = new_pixel.red;
         rsp_in.green       = new_pixel.green;
         rsp_in.blue        = new_pixel.blue;
         rsp_in.last_pixel  = last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frlfb_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `FRLFB_ASSERT_NEXT(a_tick_starts_run, clock, reset, tick_xfer,
      (state_ff == frlfb_pkg::ST_RUN) && (cnt_ff == '0), "tick did not start a run")
   `FRLFB_ASSERT_NEXT(a_last_ends_run, clock, reset, load && last,
      (state_ff == frlfb_pkg::ST_IDLE) && rsp_valid_ff && rsp_ff.last_pixel,
      "last pixel did not end the run")
   `FRLFB_ASSERT_SAME(a_last_index, clock, reset, rsp_valid_ff && rsp_ff.last_pixel,
      rsp_ff.pixel_index == 5'(PIXEL_COUNT - 1), "last pixel flag on wrong index")

endmodule

[dv/tb_fading_room_led_frame_buffer_core.sv]
// testbench for the room led frame buffer: directed and random write/tick transfers,
// a local frame predictor with fade and room painting, pixel-by-pixel output checks
// depends on frlfb_pkg and fading_room_led_frame_buffer_core
module tb_fading_room_led_frame_buffer_core;
   timeunit 1ns;
   timeprecision 1ps;
   import frlfb_pkg::*;

   localparam int RANDOM_ITEMS   = 480;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int MAX_REPORTS    = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type     request_queue[$];
   rsp_type     expected_pixels[$];
   logic [23:0] room_colors[ROOM_SLOTS];
   pixel_type   frame[PIXEL_COUNT];
   rsp_type     want;
   int unsigned request_total;
   int unsigned request_accepted = 0;
   int unsigned mismatches = 0;
   int unsigned req_wait = 0;
   int unsigned rsp_wait = 0;
   int unsigned idle_cycles = 0;
   logic        req_calm = 1'b0;
   logic        rsp_calm = 1'b0;

   fading_room_led_frame_buffer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] dimmed(input logic [7:0] c);
      return (c != 8'd0) ? c - 8'd1 : 8'd0;
   endfunction

   // calm stretches give back-to-back transfers
   function automatic int unsigned draw_wait(input logic calm);
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   // store in-range room writes; on a tick fade, paint pending rooms, emit the whole strip, then clear the rooms
   function automatic void update_frame(input req_type item);
      int slot;
      int base;
      rsp_type px;
      if (item.operation == OP_WRITE) begin
         if (item.floor_number >= 3'd1 && item.floor_number <= 3'd2 &&
             item.room_number >= 3'd1 && item.room_number <= 3'd4) begin
            slot = (int'(item.floor_number) - 1) * 4 + int'(item.room_number) - 1;
            room_colors[slot] = item.room_color;
         end
      end else begin
         foreach (frame[i]) begin
            frame[i].red   = dimmed(frame[i].red);
            frame[i].green = dimmed(frame[i].green);
            frame[i].blue  = dimmed(frame[i].blue);
         end
         for (slot = 0; slot < ROOM_SLOTS; slot++) begin
            if (room_colors[slot] != 24'd0) begin
               base = (slot / 4) * 4 + ((slot % 4) % 2) * 16 + ((slot % 4) / 2) * 2;
               frame[base]     = room_colors[slot];
               frame[base + 1] = room_colors[slot];
               frame[base + 8] = room_colors[slot];
               frame[base + 9] = room_colors[slot];
            end
         end
         for (int i = 0; i < PIXEL_COUNT; i++) begin
            px.pixel_index = i[4:0];
            px.red         = frame[i].red;
            px.green       = frame[i].green;
            px.blue        = frame[i].blue;
            px.last_pixel  = (i == PIXEL_COUNT - 1);
            expected_pixels.push_back(px);
         end
         foreach (room_colors[i]) room_colors[i] = 24'd0;
      end
   endfunction

   function automatic void queue_request(input logic op, input logic [2:0] fl,
                                         input logic [2:0] rm, input logic [23:0] color);
      req_type item;
      item.operation    = op;
      item.floor_number = fl;
      item.room_number  = rm;
      item.room_color   = color;
      request_queue.push_back(item);
   endfunction

   // small, zero, full or random channel levels, so some fades reach zero within a few ticks
   function automatic logic [23:0] pick_color();
      logic [23:0] color;
      int unsigned pick;
      if ($urandom_range(0, 19) == 0) return 24'd0;
      for (int c = 0; c < 3; c++) begin
         pick = $urandom_range(0, 9);
         if (pick < 2)      color[c*8 +: 8] = 8'd0;
         else if (pick < 5) color[c*8 +: 8] = 8'($urandom_range(1, 3));
         else if (pick < 6) color[c*8 +: 8] = 8'hFF;
         else               color[c*8 +: 8] = 8'($urandom);
      end
      return color;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_wait = 0;
         foreach (room_colors[i]) room_colors[i] = 24'd0;
         foreach (frame[i]) frame[i] = '0;
      end else begin
         if (req_valid && req_ready) begin
            update_frame(req_data);
            request_accepted++;
            if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
            req_wait = draw_wait(req_calm);
         end
         if (!req_valid || req_ready) begin
            if (req_wait == 0 && request_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= request_queue.pop_front();
            end else begin
               if (req_wait != 0) req_wait--;
               req_valid <= 1'b0;
            end
         end
      end
   end

   // pixel monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected pixel transfer: index %0d rgb %h %h %h last %b",
                           rsp_data.pixel_index, rsp_data.red, rsp_data.green,
                           rsp_data.blue, rsp_data.last_pixel);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.pixel_index !== want.pixel_index || rsp_data.red !== want.red ||
                   rsp_data.green !== want.green || rsp_data.blue !== want.blue ||
                   rsp_data.last_pixel !== want.last_pixel) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("pixel mismatch: expected idx %0d rgb %h %h %h last %b,",
                              want.pixel_index, want.red, want.green, want.blue,
                              want.last_pixel,
                              " got idx %0d rgb %h %h %h last %b",
                              rsp_data.pixel_index, rsp_data.red,
                              rsp_data.green, rsp_data.blue, rsp_data.last_pixel);
               end
            end
            if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
            rsp_wait = draw_wait(rsp_calm);
         end
         if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int counted;
      int unsigned pick;
      logic [2:0] fl;
      logic [2:0] rm;

      // every slot, channel extremes, last write wins, zero colour skips painting
      queue_request(OP_WRITE, 3'd1, 3'd1, 24'hFFFFFF);
      queue_request(OP_WRITE, 3'd1, 3'd2, 24'h000001);
      queue_request(OP_WRITE, 3'd1, 3'd3, 24'h010000);
      queue_request(OP_WRITE, 3'd1, 3'd4, 24'h00FF00);
      queue_request(OP_WRITE, 3'd1, 3'd4, 24'h0000FF);
      queue_request(OP_WRITE, 3'd2, 3'd1, 24'h800000);
      queue_request(OP_WRITE, 3'd2, 3'd2, 24'h7F7F7F);
      queue_request(OP_WRITE, 3'd2, 3'd3, 24'h000100);
      queue_request(OP_WRITE, 3'd2, 3'd3, 24'h000000);
      queue_request(OP_WRITE, 3'd2, 3'd4, 24'hFFFFFF);
      // out of range floors and rooms are dropped
      queue_request(OP_WRITE, 3'd0, 3'd1, 24'h123456);
      queue_request(OP_WRITE, 3'd3, 3'd2, 24'hABCDEF);
      queue_request(OP_WRITE, 3'd7, 3'd7, 24'hFFFFFF);
      queue_request(OP_WRITE, 3'd1, 3'd0, 24'h654321);
      queue_request(OP_WRITE, 3'd2, 3'd5, 24'hFEDCBA);
      queue_request(OP_TICK, 3'd7, 3'd7, 24'hFFFFFF);
      queue_request(OP_TICK, 3'd0, 3'd0, 24'h000000);
      queue_request(OP_WRITE, 3'd1, 3'd1, 24'h000000);
      queue_request(OP_TICK, 3'd1, 3'd1, 24'h000000);
      queue_request(OP_WRITE, 3'd2, 3'd4, 24'h010101);
      queue_request(OP_TICK, 3'd2, 3'd4, 24'h010101);
      queue_request(OP_TICK, 3'd5, 3'd2, 24'h5A5A5A);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            fl = 3'($urandom);
            rm = 3'($urandom);
            queue_request(OP_WRITE, fl, rm, 24'($urandom));
            counted++;
         end else if (pick < 75) begin
            queue_request(OP_WRITE, 3'($urandom_range(1, 2)), 3'($urandom_range(1, 4)),
                          pick_color());
            counted++;
         end else begin
            queue_request(OP_TICK, 3'($urandom), 3'($urandom), 24'($urandom));
            counted++;
         end
      end
      request_total = request_queue.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (request_accepted != request_total || expected_pixels.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
